/* sv/pebc_pkg.sv */
// Shared types and constants for the particle Euler step block.
package pebc_pkg;

  // Divider geometry: |force| * 2^16 over a 31-bit mass.
  localparam int unsigned DIV_NUM_W = 48;
  localparam int unsigned DIV_DEN_W = 31;

  // Item kinds carried on the input tuser bit.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FORCE_X     = 2'd0;
  localparam logic [1:0] CFG_FORCE_Y     = 2'd1;
  localparam logic [1:0] CFG_RESTITUTION = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_MUL_VX,
    ST_MUL_VY,
    ST_MUL_AX,
    ST_MUL_AY,
    ST_MUL_END,
    ST_BOUNCE,
    ST_BOUNCE_END,
    ST_COMMIT,
    ST_DONE
  } pebc_state_e;

  // Operand pair presented to the shared multiplier.
  typedef enum logic [2:0] {
    MUL_VX,
    MUL_VY,
    MUL_AX,
    MUL_AY,
    MUL_BNC
  } pebc_mul_e;

  // Which intermediate register takes the truncated product.
  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_X,
    CAP_Y,
    CAP_VX,
    CAP_VY,
    CAP_BNC
  } pebc_cap_e;

  typedef struct packed {
    logic      load;
    logic      take_step;
    logic      div_start;
    logic      div_sel_y;
    logic      acc_wr_x;
    logic      acc_wr_y;
    pebc_mul_e mul_sel;
    pebc_cap_e cap;
    logic      commit;
    logic      out_load;
  } pebc_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic ground;
    logic dead;
  } pebc_sts_t;

  typedef struct packed {
    logic        bounced;
    logic        is_dead;
    logic [31:0] life_left;
    logic [31:0] vel_y;
    logic [31:0] vel_x;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } pebc_result_t;

endpackage

/* sv/pebc_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module pebc_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [pebc_pkg::DIV_NUM_W-1:0]    num_i,
  input  logic [pebc_pkg::DIV_DEN_W-1:0]    den_i,
  output logic [pebc_pkg::DIV_NUM_W-1:0]    quot_o,
  output logic                              busy_o,
  output logic                              done_o
);
  import pebc_pkg::*;

  localparam int unsigned CntW = $clog2(DIV_NUM_W);
  localparam logic [CntW-1:0] CntLast = CntW'(DIV_NUM_W - 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0] quo_q, quo_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W+1:0] diff;
  logic                 ge;

  // Remainder stays below the divisor, so the shifted value fits one more bit.
  always_comb begin
    rem_sh = {rem_q, quo_q[DIV_NUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_q};
    ge     = ~diff[DIV_DEN_W+1];
    rem_d  = ge ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
    quo_d  = {quo_q[DIV_NUM_W-2:0], ge};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = CntLast;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quot_o = quo_q;
  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

/* sv/pebc_datapath.sv */
// Particle state, configuration registers, shared multiplier and divider.
module pebc_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pebc_pkg::pebc_cmd_t   cmd_i,
  output pebc_pkg::pebc_sts_t   sts_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i,
  input  logic [30:0]           step_time_i,
  input  logic [31:0]           load_pos_x_i,
  input  logic [31:0]           load_pos_y_i,
  input  logic [31:0]           load_vel_x_i,
  input  logic [31:0]           load_vel_y_i,
  input  logic [30:0]           load_mass_i,
  input  logic [31:0]           load_life_i,
  output pebc_pkg::pebc_result_t result_o
);
  import pebc_pkg::*;

  // Product truncated toward zero after dropping 16 fraction bits.
  function automatic logic signed [48:0] q_trunc(input logic signed [64:0] p);
    logic signed [64:0] adj;
    begin
      adj = p[64] ? (p + 65'sd65535) : p;
      return $signed(adj[64:16]);
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic hi_ovf;
    logic lo_ovf;
    begin
      hi_ovf = ~v[49] & (|v[48:31]);
      lo_ovf = v[49] & ~(&v[48:31]);
      if (hi_ovf) return 32'sh7FFF_FFFF;
      else if (lo_ovf) return 32'sh8000_0000;
      else return $signed(v[31:0]);
    end
  endfunction

  // Acceleration from the unsigned quotient of |force| * 2^16 / mass.
  function automatic logic signed [31:0] accel_sat(input logic [DIV_NUM_W-1:0] q,
                                                    input logic signed [31:0] f,
                                                    input logic m_zero);
    begin
      if (f == 32'sd0) return 32'sd0;
      else if (m_zero) return f[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      else if (!f[31]) return (q > 48'd2147483647) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
      else return (q > 48'd2147483648) ? 32'sh8000_0000 : $signed(-q[31:0]);
    end
  endfunction

  logic signed [31:0] force_x_q, force_y_q;
  logic [16:0]        restitution_q;
  logic signed [31:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q, life_q;
  logic [30:0]        mass_q;
  logic               dead_q, hit_q;
  logic [30:0]        dt_q;
  logic signed [31:0] acc_x_q, acc_y_q;
  logic signed [64:0] prod_q;
  logic signed [49:0] newx_q, newy_q;
  logic signed [31:0] nvx_q, nvy_q, bnc_q;
  pebc_result_t       result_q;

  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [48:0] prod_tr;
  logic signed [31:0] force_sel;
  logic [31:0]        force_mag;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_NUM_W-1:0] div_quot;
  logic               div_busy, div_done;
  logic               ground;
  logic signed [31:0] life_next;

  pebc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (mass_q),
    .quot_o (div_quot),
    .busy_o (div_busy),
    .done_o (div_done)
  );

  always_comb begin
    force_sel = cmd_i.div_sel_y ? force_y_q : force_x_q;
    force_mag = force_sel[31] ? (~force_sel + 32'd1) : force_sel;
    div_num   = {force_mag, 16'd0};
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_VX: begin
        mul_a = {vel_x_q[31], vel_x_q};
        mul_b = $signed({1'b0, dt_q});
      end
      MUL_VY: begin
        mul_a = {vel_y_q[31], vel_y_q};
        mul_b = $signed({1'b0, dt_q});
      end
      MUL_AX: begin
        mul_a = {acc_x_q[31], acc_x_q};
        mul_b = $signed({1'b0, dt_q});
      end
      MUL_AY: begin
        mul_a = {acc_y_q[31], acc_y_q};
        mul_b = $signed({1'b0, dt_q});
      end
      MUL_BNC: begin
        mul_a = -$signed({nvy_q[31], nvy_q});
        mul_b = $signed({15'd0, restitution_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 65'(mul_a) * 65'(mul_b);
  end

  assign prod_tr   = q_trunc(prod_q);
  assign ground    = (newy_q <= 50'sd0);
  assign life_next = sat32($signed({{18{life_q[31]}}, life_q}) - $signed({19'd0, dt_q}));

  // Intermediate results of one step, the bounce flag and the result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_step) dt_q <= step_time_i;
    if (cmd_i.acc_wr_x) acc_x_q <= accel_sat(div_quot, force_x_q, mass_q == '0);
    if (cmd_i.acc_wr_y) acc_y_q <= accel_sat(div_quot, force_y_q, mass_q == '0);
    unique case (cmd_i.cap)
      CAP_X:   newx_q <= $signed({{18{pos_x_q[31]}}, pos_x_q}) + 50'(prod_tr);
      CAP_Y:   newy_q <= $signed({{18{pos_y_q[31]}}, pos_y_q}) + 50'(prod_tr);
      CAP_VX:  nvx_q <= sat32($signed({{18{vel_x_q[31]}}, vel_x_q}) + 50'(prod_tr));
      CAP_VY:  nvy_q <= sat32($signed({{18{vel_y_q[31]}}, vel_y_q}) + 50'(prod_tr));
      CAP_BNC: bnc_q <= sat32(50'(prod_tr));
      default: ;
    endcase
    if (cmd_i.load) hit_q <= 1'b0;
    else if (cmd_i.commit) hit_q <= ground;
    if (cmd_i.out_load) begin
      result_q.pos_x     <= pos_x_q;
      result_q.pos_y     <= pos_y_q;
      result_q.vel_x     <= vel_x_q;
      result_q.vel_y     <= vel_y_q;
      result_q.life_left <= life_q;
      result_q.is_dead   <= dead_q;
      result_q.bounced   <= hit_q;
    end
  end

  // Architectural particle state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_x_q     <= 32'sd131072;
      force_y_q     <= -32'sd576717;
      restitution_q <= 17'd39322;
      pos_x_q       <= '0;
      pos_y_q       <= '0;
      vel_x_q       <= '0;
      vel_y_q       <= '0;
      mass_q        <= 31'd65536;
      life_q        <= '0;
      dead_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_FORCE_X:     force_x_q <= cfg_data_i;
          CFG_FORCE_Y:     force_y_q <= cfg_data_i;
          CFG_RESTITUTION: restitution_q <= cfg_data_i[16:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        pos_x_q <= load_pos_x_i;
        pos_y_q <= load_pos_y_i;
        vel_x_q <= load_vel_x_i;
        vel_y_q <= load_vel_y_i;
        mass_q  <= load_mass_i;
        life_q  <= load_life_i;
      end else if (cmd_i.commit) begin
        pos_x_q <= sat32(newx_q);
        vel_x_q <= nvx_q;
        if (ground) begin
          pos_y_q <= '0;
          vel_y_q <= bnc_q;
        end else begin
          pos_y_q <= sat32(newy_q);
          vel_y_q <= nvy_q;
        end
        life_q <= life_next;
        if (life_next <= 32'sd0) dead_q <= 1'b1;
      end
    end
  end

  assign sts_o.div_busy = div_busy;
  assign sts_o.div_done = div_done;
  assign sts_o.ground   = ground;
  assign sts_o.dead     = dead_q;
  assign result_o       = result_q;

endmodule

/* sv/pebc_ctrl.sv */
// Sequencer that steps the datapath through a load or an Euler step.
module pebc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_mode_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  pebc_pkg::pebc_sts_t sts_i,
  output pebc_pkg::pebc_cmd_t cmd_o
);
  import pebc_pkg::*;

  pebc_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_mode_i == MODE_STEP) begin
            cmd_o.take_step = 1'b1;
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV_X;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = ST_DONE;
          end
        end
      end
      ST_DIV_X: begin
        if (sts_i.div_done) begin
          cmd_o.acc_wr_x  = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel_y = 1'b1;
          state_d         = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (sts_i.div_done) begin
          cmd_o.acc_wr_y = 1'b1;
          state_d        = ST_MUL_VX;
        end
      end
      ST_MUL_VX: begin
        cmd_o.mul_sel = MUL_VX;
        state_d       = ST_MUL_VY;
      end
      ST_MUL_VY: begin
        cmd_o.mul_sel = MUL_VY;
        cmd_o.cap     = CAP_X;
        state_d       = ST_MUL_AX;
      end
      ST_MUL_AX: begin
        cmd_o.mul_sel = MUL_AX;
        cmd_o.cap     = CAP_Y;
        state_d       = ST_MUL_AY;
      end
      ST_MUL_AY: begin
        cmd_o.mul_sel = MUL_AY;
        cmd_o.cap     = CAP_VX;
        state_d       = ST_MUL_END;
      end
      ST_MUL_END: begin
        cmd_o.cap = CAP_VY;
        state_d   = sts_i.ground ? ST_BOUNCE : ST_COMMIT;
      end
      ST_BOUNCE: begin
        cmd_o.mul_sel = MUL_BNC;
        state_d       = ST_BOUNCE_END;
      end
      ST_BOUNCE_END: begin
        cmd_o.cap = CAP_BNC;
        state_d   = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

endmodule

/* sv/particle_euler_step_bounce_core.sv */
// Sequence: a load item is written into the particle and then into the result register; a step item
// runs the divisions, the multiplies, a bounce multiply when it reaches the ground, and the commit
// before its result is registered, and the next item is taken once the result register is loaded.
// The pace of a step is set by the shared one-bit-per-cycle divider, run twice, once per axis.
// The result register frees the input side: a new item transfers while a result is still held.
// Reset (rst_ni low, asynchronous) clears the particle to rest at the origin with mass 1.0,
// life 0 and no dead flag, and restores the default force and restitution registers.
module particle_euler_step_bounce_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input items.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: step_time[30:0], load_pos_x[62:31], load_pos_y[94:63],
  // load_vel_x[126:95], load_vel_y[158:127], load_mass[189:159], load_life[221:190],
  // zero fill [223:222].
  input  logic [223:0] s_axis_tdata,
  // tuser: mode (0 load, 1 step).
  input  logic         s_axis_tuser,
  // Result items.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0: pos_x[31:0], pos_y[63:32], vel_x[95:64], vel_y[127:96],
  // life_left[159:128], is_dead[160], bounced[161], zero fill [167:162].
  output logic [167:0] m_axis_tdata,
  // Configuration writes.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import pebc_pkg::*;

  pebc_cmd_t    cmd;
  pebc_sts_t    sts;
  pebc_result_t result;

  // Registers are plain flops, so a configuration transfer is always taken.
  assign cfg_ready_o = 1'b1;

  // The controller owns the handshakes and the step sequence; the datapath
  // only executes the command it is given each cycle.
  pebc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pebc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_time_i (s_axis_tdata[30:0]),
    .load_pos_x_i(s_axis_tdata[62:31]),
    .load_pos_y_i(s_axis_tdata[94:63]),
    .load_vel_x_i(s_axis_tdata[126:95]),
    .load_vel_y_i(s_axis_tdata[158:127]),
    .load_mass_i (s_axis_tdata[189:159]),
    .load_life_i (s_axis_tdata[221:190]),
    .result_o    (result)
  );

  // The struct is declared most significant member first, so it packs
  // straight into the low bits of the result word.
  assign m_axis_tdata = {6'd0, result};

  // A new item must never be taken while the divider is still working.
  a_no_accept_while_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !sts.div_busy)
    else $error("input ready while the divider is busy");

  // The divider is restarted only once the previous quotient is complete.
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  // An acceleration is captured only from a finished quotient.
  a_acc_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.acc_wr_x || cmd.acc_wr_y) |-> sts.div_done)
    else $error("acceleration captured before the divider finished");

  // The dead flag is sticky until reset.
  a_dead_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.dead |=> sts.dead)
    else $error("dead flag cleared without reset");

endmodule

/* test/particle_euler_step_bounce_core_test.sv */
// Self-checking testbench for the particle Euler step core: directed and random stimulus.
`timescale 1ns / 100ps

module particle_euler_step_bounce_core_test;
  import pebc_pkg::*;

  localparam longint Q_ONE = 64'sd65536;
  localparam longint Q_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q_MIN = -64'sh0000_0000_8000_0000;
  localparam int HOLD_CYCLES = 600;
  localparam int END_SETTLE = 120;

  // One input item as the sender sees it, before packing onto tdata.
  typedef struct packed {
    logic        mode;
    logic [30:0] step_time;
    logic [31:0] pos_x, pos_y, vel_x, vel_y;
    logic [30:0] mass;
    logic [31:0] life;
  } particle_item_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [223:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [167:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = CFG_FORCE_X;
  logic [31:0]  cfg_data_i = '0;

  // Shared between the test sequence, the receiver and the result checker.
  logic         no_idle = 1'b0;
  logic         hold_trigger = 1'b0;
  int           hold_left = 0;
  pebc_result_t expected_q[$];
  int           mismatch_count = 0;
  int           result_count = 0;
  int           load_count = 0;
  int           step_count = 0;
  int           bounce_count = 0;
  int           cfg_write_count = 0;

  // Predicted particle and register contents.
  longint              part_px = 0, part_py = 0, part_vx = 0, part_vy = 0;
  longint              part_mass = Q_ONE, part_life = 0;
  logic                part_dead = 1'b0;
  logic signed [31:0]  cfg_force_x = 32'sd131072;
  logic signed [31:0]  cfg_force_y = -32'sd576717;
  logic [16:0]         cfg_restitution = 17'd39322;

  particle_euler_step_bounce_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint saturate_q(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // Exact product of two fixed-point values, truncated toward zero.
  function automatic longint scale_q(longint a, longint b);
    return (a * b) / Q_ONE;
  endfunction

  // Force over mass; a massless particle gets the largest value of the force's sign.
  function automatic longint accel_q(longint f, longint m);
    if (m <= 0) begin
      if (f > 0) return Q_MAX;
      if (f < 0) return Q_MIN;
      return 0;
    end
    return saturate_q((f * Q_ONE) / m);
  endfunction

  // Applies one accepted item to the predicted particle and queues the result it must give.
  task automatic advance_particle(input particle_item_t it);
    pebc_result_t r;
    longint dt, ax, ay, nx, ny, nvx, nvy;
    logic hit;
    hit = 1'b0;
    if (it.mode == MODE_LOAD) begin
      part_px   = longint'($signed(it.pos_x));
      part_py   = longint'($signed(it.pos_y));
      part_vx   = longint'($signed(it.vel_x));
      part_vy   = longint'($signed(it.vel_y));
      part_mass = longint'(it.mass);
      part_life = longint'($signed(it.life));
      load_count++;
    end else begin
      dt  = longint'(it.step_time);
      ax  = accel_q(longint'(cfg_force_x), part_mass);
      ay  = accel_q(longint'(cfg_force_y), part_mass);
      nx  = part_px + scale_q(part_vx, dt);
      ny  = part_py + scale_q(part_vy, dt);
      nvx = saturate_q(part_vx + scale_q(ax, dt));
      nvy = saturate_q(part_vy + scale_q(ay, dt));
      part_px = saturate_q(nx);
      part_vx = nvx;
      // The ground test looks at the height before saturation.
      if (ny > 0) begin
        part_py = saturate_q(ny);
        part_vy = nvy;
      end else begin
        hit = 1'b1;
        part_py = 0;
        part_vy = saturate_q(scale_q(-nvy, longint'(cfg_restitution)));
        bounce_count++;
      end
      part_life = saturate_q(part_life - dt);
      if (part_life <= 0) part_dead = 1'b1;
      step_count++;
    end
    r.pos_x     = part_px[31:0];
    r.pos_y     = part_py[31:0];
    r.vel_x     = part_vx[31:0];
    r.vel_y     = part_vy[31:0];
    r.life_left = part_life[31:0];
    r.is_dead   = part_dead;
    r.bounced   = hit;
    expected_q.push_back(r);
  endtask

  // Offers one item; valid is left high after the transfer so that back-to-back items
  // go out without a drop in valid. Whoever stops sending lowers it.
  task automatic send_item(input particle_item_t it);
    while (!no_idle && $urandom_range(99) < 20) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.mode;
    s_axis_tdata  <= {2'b00, it.life, it.mass, it.vel_y, it.vel_x, it.pos_y, it.pos_x,
                      it.step_time};
    do @(posedge clk_i); while (!s_axis_tready);
    advance_particle(it);
  endtask

  // Unused fields carry random bits, since the block must ignore them.
  task automatic send_load(input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] vx, input logic [31:0] vy,
                           input logic [31:0] mass, input logic [31:0] life);
    particle_item_t it;
    it = '{mode: MODE_LOAD, step_time: 31'($urandom), pos_x: px, pos_y: py, vel_x: vx,
           vel_y: vy, mass: mass[30:0], life: life};
    send_item(it);
  endtask

  task automatic send_step(input logic [31:0] dt);
    particle_item_t it;
    it = '{mode: MODE_STEP, step_time: dt[30:0], pos_x: $urandom, pos_y: $urandom,
           vel_x: $urandom, vel_y: $urandom, mass: 31'($urandom), life: $urandom};
    send_item(it);
  endtask

  // Stops offering items and waits until every predicted result has been checked.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      CFG_FORCE_X:     cfg_force_x = value;
      CFG_FORCE_Y:     cfg_force_y = value;
      CFG_RESTITUTION: cfg_restitution = value[16:0];
      default: ;
    endcase
    cfg_write_count++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_signed(input int unsigned mag);
    return $urandom_range(2 * mag) - mag;
  endfunction

  function automatic logic [31:0] pick_force();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3, 4: return $urandom;
      default: return rand_signed(16 << 16);
    endcase
  endfunction

  // Values above 1.0 and junk in the upper data bits are legal and must be handled.
  function automatic logic [31:0] pick_restitution();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'd65536;
      2: return 32'h0001_FFFF;
      3: return $urandom;
      default: return $urandom_range(65536);
    endcase
  endfunction

  // A plausible flight: a particle at or above ground, then a run of short steps.
  task automatic fly_particle(input int unsigned steps);
    send_load(rand_signed(100 << 16), $urandom_range(50 << 16), rand_signed(20 << 16),
              rand_signed(20 << 16), $urandom_range(8 << 16, 1 << 12),
              $urandom_range(20 << 16));
    repeat (steps) send_step($urandom_range(1 << 14));
  endtask

  task automatic send_noise();
    case ($urandom_range(3))
      0: send_load($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      1: send_load($urandom, $urandom, $urandom, $urandom, 32'd0, $urandom);
      2: send_step($urandom);
      default: send_step($urandom_range(1 << 16));
    endcase
  endtask

  // Ordinary integration, a zero step, life running out and a dead particle that
  // keeps moving and stays dead across a new load.
  task automatic test_load_and_step();
    send_load(0, 100 << 16, 3 << 15, 2 << 16, 2 << 16, 1 << 16);
    send_step(1 << 13);
    send_step(0);
    send_step(1 << 15);
    send_step(1 << 15);
    send_step(1 << 14);
    send_load(-(5 << 16), 40 << 16, -(1 << 16), 0, 1 << 16, 50 << 16);
    send_step(1 << 14);
    wait_for_results();
  endtask

  // Landing exactly on the ground and falling through it.
  task automatic test_ground_bounce();
    send_load(0, 0, 1 << 16, 0, 1 << 16, 10 << 16);
    send_step(1 << 12);
    send_load(0, 1 << 16, 0, -(10 << 16), 1 << 16, 10 << 16);
    send_step(1 << 15);
    wait_for_results();
  endtask

  // Largest and smallest positions, velocities and lives, with extreme masses and the largest step.
  task automatic test_saturation();
    send_load(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1,
              32'h7FFF_FFFF);
    send_step(32'h7FFF_FFFF);
    send_load(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000);
    send_step(32'h7FFF_FFFF);
    wait_for_results();
  endtask

  task automatic test_zero_mass();
    send_load(0, 20 << 16, 0, 0, 32'd0, 10 << 16);
    send_step(1 << 14);
    wait_for_results();
  endtask

  // Extreme register settings, including restitution above 1.0 and no force at all.
  task automatic test_config_extremes();
    write_register(CFG_FORCE_X, 32'h8000_0000);
    write_register(CFG_FORCE_Y, 32'h7FFF_FFFF);
    write_register(CFG_RESTITUTION, 32'h0001_FFFF);
    send_load(0, 1 << 16, 0, -(100 << 16), 1 << 16, 10 << 16);
    send_step(1 << 16);
    send_load(0, 5 << 16, 0, 0, 32'd0, 10 << 16);
    send_step(1 << 14);
    wait_for_results();
    write_register(CFG_FORCE_X, 32'h0);
    write_register(CFG_FORCE_Y, 32'h0);
    write_register(CFG_RESTITUTION, 32'h0);
    send_load(0, 5 << 16, 1 << 16, 0, 32'd0, 10 << 16);
    send_step(1 << 14);
    send_load(0, 1 << 15, 0, -(8 << 16), 1 << 16, 10 << 16);
    send_step(1 << 16);
    wait_for_results();
    write_register(CFG_FORCE_X, 32'h7FFF_FFFF);
    write_register(CFG_FORCE_Y, 32'h8000_0000);
    write_register(CFG_RESTITUTION, 32'd65536);
    send_load(0, 2 << 16, 0, 0, 3 << 16, 10 << 16);
    send_step(1 << 15);
    wait_for_results();
    write_register(CFG_FORCE_X, 32'd131072);
    write_register(CFG_FORCE_Y, -32'sd576717);
    write_register(CFG_RESTITUTION, 32'd39322);
  endtask

  // Mostly well-formed flights with random content, plus noise, over several settings.
  task automatic test_random_flights();
    int unsigned sent, steps;
    for (int phase = 0; phase < 8; phase++) begin
      wait_for_results();
      write_register(CFG_FORCE_X, pick_force());
      write_register(CFG_FORCE_Y, pick_force());
      write_register(CFG_RESTITUTION, pick_restitution());
      sent = 0;
      while (sent < 95) begin
        if ($urandom_range(99) < 80) begin
          steps = $urandom_range(14, 4);
          fly_particle(steps);
          sent += steps + 1;
        end else begin
          send_noise();
          sent++;
        end
      end
    end
    wait_for_results();
  endtask

  // The receiver stops for a long while; the sender keeps offering until the core stalls.
  task automatic test_output_backpressure();
    hold_trigger <= 1'b1;
    @(posedge clk_i);
    hold_trigger <= 1'b0;
    send_load(0, 10 << 16, 1 << 16, 1 << 16, 1 << 16, 30 << 16);
    repeat (3) send_step(1 << 13);
    send_load(1 << 16, 0, 0, -(1 << 16), 1 << 16, 30 << 16);
    repeat (3) send_step(1 << 13);
    wait_for_results();
  endtask

  // Neither side idles here, so items and results go at the core's full pace.
  task automatic test_steady_stream();
    no_idle <= 1'b1;
    @(posedge clk_i);
    repeat (6) fly_particle(9);
    wait_for_results();
    no_idle <= 1'b0;
  endtask

  // Result ready: long hold-offs on request, random stalls otherwise.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_trigger) begin
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 20);
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("Result %0d: %s expected %h, got %h", result_count, name, want, got);
    end
  endtask

  // Every result transfer is checked against the oldest prediction.
  always @(posedge clk_i) begin
    pebc_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = pebc_result_t'(m_axis_tdata[161:0]);
      result_count++;
      if (expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Result %0d arrived with none expected: %h", result_count, m_axis_tdata);
      end else begin
        want = expected_q.pop_front();
        compare_field("pos_x", want.pos_x, got.pos_x);
        compare_field("pos_y", want.pos_y, got.pos_y);
        compare_field("vel_x", want.vel_x, got.vel_x);
        compare_field("vel_y", want.vel_y, got.vel_y);
        compare_field("life_left", want.life_left, got.life_left);
        compare_field("is_dead", 32'(want.is_dead), 32'(got.is_dead));
        compare_field("bounced", 32'(want.bounced), 32'(got.bounced));
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_load_and_step();
    test_ground_bounce();
    test_saturation();
    test_zero_mass();
    test_config_extremes();
    test_random_flights();
    test_output_backpressure();
    test_steady_stream();
    wait_for_results();
    repeat (END_SETTLE) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      mismatch_count += expected_q.size();
      $display("%0d expected results never arrived", expected_q.size());
    end
    $display("Ran %0d loads and %0d Euler steps (%0d ground hits) over %0d register writes.",
             load_count, step_count, bounce_count, cfg_write_count);
    $display("Checked %0d results, %0d mismatching fields or stray results.",
             result_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("Timeout: %0d results still expected", expected_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* sim.f */
sv/pebc_pkg.sv
sv/pebc_div.sv
sv/pebc_datapath.sv
sv/pebc_ctrl.sv
sv/particle_euler_step_bounce_core.sv
test/particle_euler_step_bounce_core_test.sv
